// File: rtl/core/fbfl_pkg.sv
// Shared types and constants for the fixed-size block free list.
// No dependencies; imported by the core and by the shared multiplier.
`default_nettype none

package fbfl_pkg;

  // Field widths of the command and result ports
  localparam int unsigned OP_W      = 2;
  localparam int unsigned FIDX_W    = 8;
  localparam int unsigned OFF_W     = 21;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned NB_W      = 9;
  localparam int unsigned BB_W      = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values
  localparam int unsigned NB_RESET = 256;
  localparam int unsigned BB_RESET = 8;

  // Free counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Rounded block size and shared multiplier operand widths
  localparam int unsigned RND_W   = 14;
  localparam int unsigned MUL_A_W = 16;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BLOCKS  = 2'd0,
    REG_BLOCK_BYTES = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

// File: rtl/core/fbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fbfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fbfl_mul.sv
// Shared multiplier with registered product, used for size rounding and offsets.
// Depends on fbfl_pkg.
`default_nettype none

module fbfl_mul (
  input  wire logic                     clk_i,
  input  wire fbfl_pkg::mul_req_t       req_i,
  output logic [fbfl_pkg::PROD_W-1:0]   prod_o
);

  import fbfl_pkg::*;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fixed_block_free_list.sv
// Fixed-size block allocator: LIFO free list in a link RAM, with sequencer.
// Depends on fbfl_pkg, fbfl_ram and fbfl_mul.
//
// Commands are taken on start while busy is low; each gives exactly one
// result, shown for one cycle with done_o high. The receiver cannot stall,
// so results must be captured in the cycle they appear. Free, allocate on
// an empty pool and the unused op code give their result in the cycle after
// the transfer and leave busy low. A successful allocate passes through
// S_ALLOC: the link RAM read of the head block and the shared multiplier
// computing index times rounded size both land in the cycle after the
// transfer. Reinitialise sweeps the whole link RAM, one entry per cycle,
// with busy high throughout, and gives its result once the last entry is
// written. After reset the same clearing pass runs with busy high;
// configuration transfers are taken meanwhile. A block_bytes write keeps
// busy high through the rounding steps RND_DIV and RND_MUL while the shared
// multiplier rounds the size up to whole words.
`default_nettype none

module fixed_block_free_list #(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned WORD_BYTES = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fbfl_pkg::OP_W-1:0]       op_i,
  input  wire logic [fbfl_pkg::FIDX_W-1:0]     free_index_i,
  // configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fbfl_pkg::BB_W-1:0]       cfg_data_i,
  // result channel
  output logic                                 done_o,
  output logic [fbfl_pkg::FIDX_W-1:0]          block_index_o,
  output logic [fbfl_pkg::OFF_W-1:0]           byte_offset_o,
  output logic [1:0]                           status_o,
  output logic [fbfl_pkg::CNT_W-1:0]           free_count_o
);

  import fbfl_pkg::*;

  // Block index and link widths; a link holds MAX_BLOCKS as its null code
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW     = (LINK_W > NB_W) ? LINK_W : NB_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // Rounding by reciprocal: words = ((bytes + W - 1) * RECIP) >> RND_SH,
  // exact for every operand below 2**RND_W
  localparam int unsigned RND_SH = RND_W + $clog2(WORD_BYTES);
  localparam int unsigned RECIP  = ((1 << RND_SH) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int unsigned RST_ROUND =
    ((BB_RESET + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
  localparam int unsigned RST_N = (MAX_BLOCKS < NB_RESET) ? MAX_BLOCKS : NB_RESET;
  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_BLOCKS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC
  } state_e;

  typedef enum logic [1:0] {
    RND_IDLE,
    RND_DIV,
    RND_MUL
  } rnd_e;

  state_e state_q;
  rnd_e   rnd_q;

  logic [IDX_W-1:0]  sweep_q;
  logic [LINK_W-1:0] init_n_q;    // block count latched for the sweep
  logic              from_op_q;   // sweep was started by a command
  logic [LINK_W-1:0] head_q;
  logic [IDX_W-1:0]  blk_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NB_W-1:0]   num_blocks_q;
  logic [RND_W-1:0]  rounded_q;

  logic              done_q;
  logic [FIDX_W-1:0] bidx_q;
  logic [OFF_W-1:0]  off_q;
  status_e           status_q;

  op_e               op;
  logic              accept;
  logic              cfg_fire;
  logic              head_null;
  logic              in_range;
  logic [EW-1:0]     eff;
  logic [LINK_W-1:0] sweep_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;

  assign op        = op_e'(op_i);
  assign busy      = (state_q != S_IDLE) || (rnd_q != RND_IDLE);
  assign accept    = start && !busy;
  // no register write in the cycle of a command transfer or mid-allocate
  assign cfg_ready_o = (rnd_q == RND_IDLE) && (state_q != S_ALLOC) &&
                       !((state_q == S_IDLE) && start);
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign head_null = (head_q == NULL_LINK);

  // effective block count: num_blocks clamped to the pool size
  always_comb begin
    if (EW'(num_blocks_q) > EW'(MAX_BLOCKS)) begin
      eff = EW'(MAX_BLOCKS);
    end else begin
      eff = EW'(num_blocks_q);
    end
  end

  assign in_range  = EW'(free_index_i) < eff;
  assign sweep_nxt = LINK_W'(sweep_q) + LINK_W'(1);

  // RAM and multiplier steering; the users never overlap in time
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = (sweep_nxt < init_n_q) ? sweep_nxt : NULL_LINK;
    ram_re    = 1'b0;
    ram_raddr = IDX_W'(head_q);
    mul_req   = '0;

    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end

    if (accept) begin
      unique case (op)
        OP_ALLOC: begin
          if (!head_null) begin
            ram_re    = 1'b1;
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(IDX_W'(head_q));
            mul_req.b  = MUL_B_W'(rounded_q);
          end
        end
        OP_FREE: begin
          if (in_range) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(free_index_i);
            ram_wdata = head_q;
          end
        end
        default: ;
      endcase
    end

    // size rounding, step one: scaled reciprocal of the padded size
    if (cfg_fire && (cfg_index_i == REG_BLOCK_BYTES)) begin
      mul_req.en = 1'b1;
      mul_req.a  = MUL_A_W'(RND_W'(cfg_data_i) + RND_W'(WORD_BYTES - 1));
      mul_req.b  = MUL_B_W'(RECIP);
    end

    // step two: whole words back to bytes
    if (rnd_q == RND_DIV) begin
      mul_req.en = 1'b1;
      mul_req.a  = MUL_A_W'(prod[RND_SH +: RND_W]);
      mul_req.b  = MUL_B_W'(WORD_BYTES);
    end
  end

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fbfl_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Sequencer, rounding steps and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      rnd_q        <= RND_IDLE;
      sweep_q      <= '0;
      init_n_q     <= LINK_W'(RST_N);
      from_op_q    <= 1'b0;
      head_q       <= NULL_LINK;
      blk_q        <= '0;
      cnt_q        <= '0;
      num_blocks_q <= NB_W'(NB_RESET);
      rounded_q    <= RND_W'(RST_ROUND);
      done_q       <= 1'b0;
      bidx_q       <= '0;
      off_q        <= '0;
      status_q     <= ST_OK;
    end else begin
      done_q <= 1'b0;

      unique case (rnd_q)
        RND_DIV: rnd_q <= RND_MUL;
        RND_MUL: begin
          rounded_q <= prod[RND_W-1:0];
          rnd_q     <= RND_IDLE;
        end
        default: ;
      endcase

      if (cfg_fire) begin
        if (cfg_index_i == REG_NUM_BLOCKS) begin
          num_blocks_q <= cfg_data_i[NB_W-1:0];
        end else if (cfg_index_i == REG_BLOCK_BYTES) begin
          rnd_q <= RND_DIV;
        end
      end

      unique case (state_q)
        S_CLEAR: begin
          if (sweep_q == SWEEP_LAST) begin
            sweep_q <= '0;
            head_q  <= (init_n_q != '0) ? '0 : NULL_LINK;
            cnt_q   <= CNT_W'(init_n_q);
            state_q <= S_IDLE;
            if (from_op_q) begin
              done_q   <= 1'b1;
              bidx_q   <= '0;
              off_q    <= '0;
              status_q <= ST_OK;
            end
          end else begin
            sweep_q <= sweep_q + IDX_W'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_ALLOC: begin
                if (head_null) begin
                  done_q   <= 1'b1;
                  bidx_q   <= '0;
                  off_q    <= '0;
                  status_q <= ST_EMPTY;
                end else begin
                  blk_q   <= IDX_W'(head_q);
                  state_q <= S_ALLOC;
                end
              end
              OP_FREE: begin
                done_q <= 1'b1;
                bidx_q <= '0;
                off_q  <= '0;
                if (in_range) begin
                  head_q   <= LINK_W'(free_index_i);
                  status_q <= ST_OK;
                  if (cnt_q != CNT_MAX) begin
                    cnt_q <= cnt_q + CNT_W'(1);
                  end
                end else begin
                  status_q <= ST_RANGE;
                end
              end
              OP_INIT: begin
                init_n_q  <= LINK_W'(eff);
                from_op_q <= 1'b1;
                sweep_q   <= '0;
                state_q   <= S_CLEAR;
              end
              default: begin
                // unused code: plain acknowledge with the current count
                done_q   <= 1'b1;
                bidx_q   <= '0;
                off_q    <= '0;
                status_q <= ST_OK;
              end
            endcase
          end
        end

        S_ALLOC: begin
          // link read and offset product have landed
          head_q <= ram_rdata;
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
          done_q   <= 1'b1;
          bidx_q   <= FIDX_W'(blk_q);
          off_q    <= prod[OFF_W-1:0] + OFF_W'(WORD_BYTES);
          status_q <= ST_OK;
          state_q  <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign block_index_o = bidx_q;
  assign byte_offset_o = off_q;
  assign status_o      = status_q;
  assign free_count_o  = cnt_q;

  // every transfer either answers at once or holds busy
  a_accept_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_q || busy))
    else $error("command transfer neither answered nor busy");

  // a register write never lands with a command transfer
  a_cfg_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_fire && accept))
    else $error("register write coincides with command transfer");

  // the head is a block or the null code, never beyond
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NULL_LINK)
    else $error("free list head beyond null code");

endmodule

`default_nettype wire
